>>> rtl/core/gpcc_pkg.sv
`timescale 1ns / 1ps
// Package for the grid path connection check core: widths, codes, state type
// and the bounds helper. Depends on nothing; every other source file uses it.
package gpcc_pkg;

   localparam int GPCC_GRID_SIDE = 256;
   localparam int COORD_W        = 10;
   localparam int SIZE_W         = 9;
   localparam int LIM_W          = 10;
   localparam int DIST_W         = 10;
   localparam int ERR_W          = 12;
   localparam int E2_W           = ERR_W + 1;
   localparam int CSR_IDX_W      = 1;

   localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(256);

   typedef enum logic {
      FUNC_WRITE = 1'b0,
      FUNC_CHECK = 1'b1
   } func_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GRID_WIDTH  = 1'b0,
      CSR_GRID_HEIGHT = 1'b1
   } csr_idx_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DECODE,
      ST_SETUP,
      ST_WALK,
      ST_RESP
   } state_type;

   function automatic logic coord_in_range(input logic signed [COORD_W-1:0] c,
                                           input logic [LIM_W-1:0] lim);
      return !c[COORD_W-1] && ({1'b0, c[COORD_W-2:0]} < lim);
   endfunction

endpackage

>>> rtl/core/gpcc_ifs.sv
`timescale 1ns / 1ps
// Channel interfaces of the grid path connection check core: request,
// response and register write. Depends on gpcc_pkg for field widths.
interface gpcc_req_if;
   logic                                   valid;
   logic                                   ready;
   logic                                   func;
   logic signed [gpcc_pkg::COORD_W-1:0]    from_x;
   logic signed [gpcc_pkg::COORD_W-1:0]    from_y;
   logic signed [gpcc_pkg::COORD_W-1:0]    to_x;
   logic signed [gpcc_pkg::COORD_W-1:0]    to_y;
   logic                                   cell_walkable;

   modport source (output valid, func, from_x, from_y, to_x, to_y, cell_walkable,
                   input ready);
   modport sink (input valid, func, from_x, from_y, to_x, to_y, cell_walkable,
                 output ready);
endinterface

interface gpcc_rsp_if;
   logic valid;
   logic ready;
   logic connected;
   logic line_walked;

   modport source (output valid, connected, line_walked, input ready);
   modport sink (input valid, connected, line_walked, output ready);
endinterface

interface gpcc_csr_if;
   logic                                valid;
   logic                                ready;
   logic [gpcc_pkg::CSR_IDX_W-1:0]      index;
   logic [gpcc_pkg::SIZE_W-1:0]         wdata;

   modport source (output valid, index, wdata, input ready);
   modport sink (input valid, index, wdata, output ready);
endinterface

>>> rtl/core/gpcc_grid_map.sv
`timescale 1ns / 1ps
// One-bit walkability map with a registered read port, one write port and a
// clearing sweep after reset. Depends on gpcc_pkg.
module gpcc_grid_map #(
   parameter int GRID_SIDE = gpcc_pkg::GPCC_GRID_SIDE
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              wr_en,
   input  logic [2*$clog2(GRID_SIDE)-1:0]    wr_addr,
   input  logic                              wr_bit,
   input  logic [2*$clog2(GRID_SIDE)-1:0]    rd_addr,
   output logic                              rd_bit,
   output logic                              clear_busy
);
   import gpcc_pkg::*;

   localparam int ADDR_W = 2 * $clog2(GRID_SIDE);
   localparam int DEPTH  = 1 << ADDR_W;

   logic              mem_ff [DEPTH];
   logic              rd_bit_ff;
   logic              clearing_ff, clearing_in;
   logic [ADDR_W-1:0] clr_cnt_ff, clr_cnt_in;

   always_comb begin
      clr_cnt_in  = clr_cnt_ff;
      clearing_in = clearing_ff;
      if (clearing_ff) begin
         clr_cnt_in = clr_cnt_ff + ADDR_W'(1);
         if (clr_cnt_ff == {ADDR_W{1'b1}}) begin
            clearing_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_cnt_ff  <= '0;
      end else begin
         clearing_ff <= clearing_in;
         clr_cnt_ff  <= clr_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (clearing_ff) begin
         mem_ff[clr_cnt_ff] <= 1'b0;
      end else if (wr_en) begin
         mem_ff[wr_addr] <= wr_bit;
      end
      rd_bit_ff <= mem_ff[rd_addr];
   end

   assign rd_bit     = rd_bit_ff;
   assign clear_busy = clearing_ff;

endmodule

>>> rtl/core/grid_path_connection_check_core.sv
`timescale 1ns / 1ps
// Top level of the grid path connection check core: sequencer, line stepper
// and size registers. Depends on gpcc_pkg, gpcc_ifs and gpcc_grid_map.
//
//   Channel   Dir   Beat contents
//   req_if    in    func, from_x, from_y, to_x, to_y, cell_walkable
//   rsp_if    out   connected, line_walked (one beat per check, none per write)
//   csr_if    in    index, wdata (grid_width = 0, grid_height = 1)
//
// A write passes through decode, where the map is written if the cell lies on the grid.
// A check passes through decode, setup and the response state, which waits until the
// output register is free; a diagonal step also reads up to two neighbor cells in the
// walk state, and a line walk reads up to max(|dx|, |dy|) + 1 cells, paced by the map read port.
// After reset the map is cleared one cell per cycle, all 2**(2*clog2(GRID_SIDE))
// cells, 65536 at the default size; no request is taken meanwhile.
// A finished response waits in its output register while the next request is taken.
module grid_path_connection_check_core #(
   parameter int GRID_SIDE = gpcc_pkg::GPCC_GRID_SIDE
) (
   input  logic         clock,
   input  logic         reset,
   gpcc_req_if.sink     req_if,
   gpcc_rsp_if.source   rsp_if,
   gpcc_csr_if.sink     csr_if
);
   import gpcc_pkg::*;

   localparam int AW     = $clog2(GRID_SIDE);
   localparam int ADDR_W = 2 * AW;
   localparam logic [LIM_W-1:0] SIDE_LIM = LIM_W'(GRID_SIDE);

   state_type state_ff, state_in;

   logic [SIZE_W-1:0] width_ff, width_in;
   logic [SIZE_W-1:0] height_ff, height_in;
   logic [LIM_W-1:0]  lim_x, lim_y;

   logic                       func_ff, func_in;
   logic                       cell_ff, cell_in;
   logic signed [COORD_W-1:0]  fx_ff, fx_in, fy_ff, fy_in, tx_ff, tx_in, ty_ff, ty_in;
   logic [DIST_W-1:0]          dx_ff, dx_in, dy_ff, dy_in;
   logic                       sx_neg_ff, sx_neg_in, sy_neg_ff, sy_neg_in;
   logic signed [ERR_W-1:0]    err_ff, err_in;
   logic signed [COORD_W-1:0]  cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   logic signed [COORD_W-1:0]  end_x_ff, end_x_in, end_y_ff, end_y_in;
   logic                       diag_ff, diag_in;
   logic                       pend_valid_ff, pend_valid_in;
   logic                       pend_inb_ff, pend_inb_in;
   logic                       pend_last_ff, pend_last_in;
   logic                       res_conn_ff, res_conn_in;
   logic                       res_line_ff, res_line_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       rsp_conn_ff, rsp_conn_in;
   logic                       rsp_line_ff, rsp_line_in;

   logic signed [COORD_W:0]    diff_x, diff_y;
   logic signed [E2_W-1:0]     e2, dx_s, dy_s;
   logic                       cur_last, cur_inb;
   logic                       walk_fail, walk_ok;
   logic                       rsp_slot_free;
   logic                       is_long, is_diag;

   logic                       seq_wr_en;
   logic [ADDR_W-1:0]          seq_wr_addr;
   logic [ADDR_W-1:0]          rd_addr;
   logic                       rd_bit;
   logic                       clear_busy;

   gpcc_grid_map #(
      .GRID_SIDE (GRID_SIDE)
   ) u_map (
      .clock      (clock),
      .reset      (reset),
      .wr_en      (seq_wr_en),
      .wr_addr    (seq_wr_addr),
      .wr_bit     (cell_ff),
      .rd_addr    (rd_addr),
      .rd_bit     (rd_bit),
      .clear_busy (clear_busy)
   );

   assign lim_x = ({1'b0, width_ff} > SIDE_LIM) ? SIDE_LIM : {1'b0, width_ff};
   assign lim_y = ({1'b0, height_ff} > SIDE_LIM) ? SIDE_LIM : {1'b0, height_ff};

   assign diff_x = $signed({tx_ff[COORD_W-1], tx_ff}) - $signed({fx_ff[COORD_W-1], fx_ff});
   assign diff_y = $signed({ty_ff[COORD_W-1], ty_ff}) - $signed({fy_ff[COORD_W-1], fy_ff});

   assign dx_s = $signed({{(E2_W-DIST_W){1'b0}}, dx_ff});
   assign dy_s = $signed({{(E2_W-DIST_W){1'b0}}, dy_ff});
   assign e2   = $signed({err_ff, 1'b0});

   assign cur_last = (cur_x_ff == end_x_ff) && (cur_y_ff == end_y_ff);
   assign cur_inb  = coord_in_range(cur_x_ff, lim_x) && coord_in_range(cur_y_ff, lim_y);

   assign walk_fail     = pend_valid_ff && (!pend_inb_ff || !rd_bit);
   assign walk_ok       = pend_valid_ff && !walk_fail && pend_last_ff;
   assign rsp_slot_free = !rsp_valid_ff || rsp_if.ready;

   assign is_long = (dx_ff > DIST_W'(1)) || (dy_ff > DIST_W'(1));
   assign is_diag = (dx_ff == DIST_W'(1)) && (dy_ff == DIST_W'(1));

   assign rd_addr     = {cur_y_ff[AW-1:0], cur_x_ff[AW-1:0]};
   assign seq_wr_addr = {fy_ff[AW-1:0], fx_ff[AW-1:0]};

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (!clear_busy) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_if.valid) begin
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            state_in = (func_ff == FUNC_WRITE) ? ST_IDLE : ST_SETUP;
         end
         ST_SETUP: begin
            state_in = (is_long || is_diag) ? ST_WALK : ST_RESP;
         end
         ST_WALK: begin
            if (walk_fail || walk_ok) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (rsp_slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Outputs and datapath.
   always_comb begin
      req_if.ready = (state_ff == ST_IDLE);
      csr_if.ready = 1'b1;
      seq_wr_en    = 1'b0;

      width_in  = width_ff;
      height_in = height_ff;
      if (csr_if.valid) begin
         case (csr_idx_type'(csr_if.index))
            CSR_GRID_WIDTH:  width_in  = csr_if.wdata;
            CSR_GRID_HEIGHT: height_in = csr_if.wdata;
            default: begin
               width_in = width_ff;
            end
         endcase
      end

      func_in       = func_ff;
      cell_in       = cell_ff;
      fx_in         = fx_ff;
      fy_in         = fy_ff;
      tx_in         = tx_ff;
      ty_in         = ty_ff;
      dx_in         = dx_ff;
      dy_in         = dy_ff;
      sx_neg_in     = sx_neg_ff;
      sy_neg_in     = sy_neg_ff;
      err_in        = err_ff;
      cur_x_in      = cur_x_ff;
      cur_y_in      = cur_y_ff;
      end_x_in      = end_x_ff;
      end_y_in      = end_y_ff;
      diag_in       = diag_ff;
      pend_valid_in = pend_valid_ff;
      pend_inb_in   = pend_inb_ff;
      pend_last_in  = pend_last_ff;
      res_conn_in   = res_conn_ff;
      res_line_in   = res_line_ff;

      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_conn_in  = rsp_conn_ff;
      rsp_line_in  = rsp_line_ff;

      case (state_ff)
         ST_IDLE: begin
            func_in = req_if.func;
            cell_in = req_if.cell_walkable;
            fx_in   = req_if.from_x;
            fy_in   = req_if.from_y;
            tx_in   = req_if.to_x;
            ty_in   = req_if.to_y;
         end
         ST_DECODE: begin
            seq_wr_en = (func_ff == FUNC_WRITE) &&
                        coord_in_range(fx_ff, lim_x) && coord_in_range(fy_ff, lim_y);
            dx_in     = diff_x[COORD_W] ? DIST_W'(-diff_x) : DIST_W'(diff_x);
            dy_in     = diff_y[COORD_W] ? DIST_W'(-diff_y) : DIST_W'(diff_y);
            sx_neg_in = !(diff_x > 0);
            sy_neg_in = !(diff_y > 0);
         end
         ST_SETUP: begin
            pend_valid_in = 1'b0;
            err_in        = ERR_W'(dx_s - dy_s);
            res_line_in   = is_long;
            res_conn_in   = 1'b1;
            if (is_long) begin
               diag_in  = 1'b0;
               cur_x_in = fx_ff;
               cur_y_in = fy_ff;
               end_x_in = tx_ff;
               end_y_in = ty_ff;
            end else begin
               diag_in  = 1'b1;
               cur_x_in = tx_ff;
               cur_y_in = fy_ff;
               end_x_in = fx_ff;
               end_y_in = ty_ff;
            end
         end
         ST_WALK: begin
            if (walk_fail) begin
               res_conn_in   = 1'b0;
               pend_valid_in = 1'b0;
            end else if (walk_ok) begin
               res_conn_in   = 1'b1;
               pend_valid_in = 1'b0;
            end else begin
               pend_valid_in = 1'b1;
               pend_inb_in   = cur_inb;
               pend_last_in  = cur_last;
               if (diag_ff) begin
                  cur_x_in = end_x_ff;
                  cur_y_in = end_y_ff;
               end else begin
                  if (e2 > -dy_s) begin
                     cur_x_in = sx_neg_ff ? cur_x_ff - COORD_W'(1) : cur_x_ff + COORD_W'(1);
                  end
                  if (e2 < dx_s) begin
                     cur_y_in = sy_neg_ff ? cur_y_ff - COORD_W'(1) : cur_y_ff + COORD_W'(1);
                  end
                  err_in = ERR_W'($signed({err_ff[ERR_W-1], err_ff})
                                  - ((e2 > -dy_s) ? dy_s : E2_W'(0))
                                  + ((e2 < dx_s) ? dx_s : E2_W'(0)));
               end
            end
         end
         ST_RESP: begin
            if (rsp_slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_conn_in  = res_conn_ff;
               rsp_line_in  = res_line_ff;
            end
         end
         default: begin
            seq_wr_en = 1'b0;
         end
      endcase

      rsp_if.valid       = rsp_valid_ff;
      rsp_if.connected   = rsp_conn_ff;
      rsp_if.line_walked = rsp_line_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         width_ff      <= SIZE_RESET;
         height_ff     <= SIZE_RESET;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         width_ff      <= width_in;
         height_ff     <= height_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff      <= func_in;
      cell_ff      <= cell_in;
      fx_ff        <= fx_in;
      fy_ff        <= fy_in;
      tx_ff        <= tx_in;
      ty_ff        <= ty_in;
      dx_ff        <= dx_in;
      dy_ff        <= dy_in;
      sx_neg_ff    <= sx_neg_in;
      sy_neg_ff    <= sy_neg_in;
      err_ff       <= err_in;
      cur_x_ff     <= cur_x_in;
      cur_y_ff     <= cur_y_in;
      end_x_ff     <= end_x_in;
      end_y_ff     <= end_y_in;
      diag_ff      <= diag_in;
      pend_inb_ff  <= pend_inb_in;
      pend_last_ff <= pend_last_in;
      res_conn_ff  <= res_conn_in;
      res_line_ff  <= res_line_in;
      rsp_conn_ff  <= rsp_conn_in;
      rsp_line_ff  <= rsp_line_in;
   end

   a_rsp_from_resp: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_if.valid) |-> $past(state_ff == ST_RESP))
      else $error("Response appeared outside the response state.");

   a_no_write_while_clearing: assert property (@(posedge clock) disable iff (reset)
      clear_busy |-> !seq_wr_en)
      else $error("Map write issued during the clearing sweep.");

   a_accept_to_decode: assert property (@(posedge clock) disable iff (reset)
      (req_if.valid && req_if.ready) |=> (state_ff == ST_DECODE))
      else $error("Accepted request did not enter decode.");

   a_pend_only_walk: assert property (@(posedge clock) disable iff (reset)
      (pend_valid_ff && state_ff != ST_WALK) |-> $past(state_ff == ST_WALK))
      else $error("Pending map read outlived the walk.");

endmodule

>>> tb/gpcc_conn_checker.sv
`timescale 1ns / 1ps
// Checker for the grid path connection check core: watches the request, response and
// register channels, predicts every check result and compares it beat by beat.
// Depends on gpcc_pkg and the channel interfaces of gpcc_ifs.
module gpcc_conn_checker (
   input  logic clock,
   input  logic reset,
   gpcc_req_if  req_mon,
   gpcc_rsp_if  rsp_mon,
   gpcc_csr_if  csr_mon,
   output int   fail_count,
   output int   pending_count
);
   import gpcc_pkg::*;

   localparam int MAP_CELLS = GPCC_GRID_SIDE * GPCC_GRID_SIDE;

   typedef struct packed {
      logic connected;
      logic line_walked;
   } conn_result_type;

   conn_result_type   conn_expected[$];
   bit                walk_map[MAP_CELLS];
   logic [SIZE_W-1:0] width_reg;
   logic [SIZE_W-1:0] height_reg;

   function automatic int size_limit(input logic [SIZE_W-1:0] r);
      return (int'(r) > GPCC_GRID_SIDE) ? GPCC_GRID_SIDE : int'(r);
   endfunction

   function automatic bit on_grid(input int x, input int y);
      return x >= 0 && y >= 0 && x < size_limit(width_reg) && y < size_limit(height_reg);
   endfunction

   function automatic bit cell_open(input int x, input int y);
      if (!on_grid(x, y)) return 1'b0;
      return walk_map[y * GPCC_GRID_SIDE + x];
   endfunction

   function automatic bit line_clear(input int x0, input int y0, input int x1, input int y1);
      int dx, dy, sx, sy, err, e2, x, y;
      bit done, clear;
      dx = (x1 > x0) ? x1 - x0 : x0 - x1;
      dy = (y1 > y0) ? y1 - y0 : y0 - y1;
      sx = (x1 > x0) ? 1 : -1;
      sy = (y1 > y0) ? 1 : -1;
      err = dx - dy;
      x = x0;
      y = y0;
      done = 1'b0;
      clear = 1'b0;
      while (!done) begin
         if (!cell_open(x, y)) begin
            done = 1'b1;
         end else if (x == x1 && y == y1) begin
            clear = 1'b1;
            done = 1'b1;
         end else begin
            e2 = 2 * err;
            if (e2 > -dy) begin
               err -= dy;
               x += sx;
            end
            if (e2 < dx) begin
               err += dx;
               y += sy;
            end
         end
      end
      return clear;
   endfunction

   function automatic conn_result_type predict_move(input int fx, input int fy,
                                                    input int tx, input int ty);
      conn_result_type res;
      int dx, dy;
      dx = (tx > fx) ? tx - fx : fx - tx;
      dy = (ty > fy) ? ty - fy : fy - ty;
      if (dx > 1 || dy > 1) begin
         res.connected = line_clear(fx, fy, tx, ty);
         res.line_walked = 1'b1;
      end else if (dx == 1 && dy == 1) begin
         res.connected = cell_open(tx, fy) && cell_open(fx, ty);
         res.line_walked = 1'b0;
      end else begin
         res.connected = 1'b1;
         res.line_walked = 1'b0;
      end
      return res;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("%0t: %s", $time, msg);
      fail_count++;
   endtask

   always @(posedge clock) begin : watch
      int fx, fy, tx, ty;
      conn_result_type want;
      if (reset) begin
         walk_map = '{default: 1'b0};
         width_reg = SIZE_RESET;
         height_reg = SIZE_RESET;
         conn_expected.delete();
         fail_count = 0;
         pending_count = 0;
      end else begin
         if (csr_mon.valid && csr_mon.ready) begin
            if (csr_mon.index == CSR_GRID_WIDTH) width_reg = csr_mon.wdata;
            else height_reg = csr_mon.wdata;
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (conn_expected.size() == 0) begin
               report_mismatch($sformatf("response beat with no check pending (%0b %0b)",
                                         rsp_mon.connected, rsp_mon.line_walked));
            end else begin
               want = conn_expected.pop_front();
               if (rsp_mon.connected !== want.connected)
                  report_mismatch($sformatf("connected is %0b, predicted %0b",
                                            rsp_mon.connected, want.connected));
               if (rsp_mon.line_walked !== want.line_walked)
                  report_mismatch($sformatf("line_walked is %0b, predicted %0b",
                                            rsp_mon.line_walked, want.line_walked));
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            fx = req_mon.from_x;
            fy = req_mon.from_y;
            tx = req_mon.to_x;
            ty = req_mon.to_y;
            if (req_mon.func == FUNC_WRITE) begin
               if (on_grid(fx, fy)) walk_map[fy * GPCC_GRID_SIDE + fx] = req_mon.cell_walkable;
            end else begin
               conn_expected = {conn_expected, predict_move(fx, fy, tx, ty)};
            end
         end
         pending_count = conn_expected.size();
      end
   end

endmodule

>>> tb/tb_grid_path_connection_check_core.sv
`timescale 1ns / 1ps
// Top of the grid path connection check core testbench: clock, reset, stimulus and verdict.
// Depends on gpcc_pkg, gpcc_ifs, the core and the gpcc_conn_checker module.
module tb_grid_path_connection_check_core;
   import gpcc_pkg::*;

   localparam int PHASES      = 8;
   localparam int PHASE_BEATS = 140;

   logic clock;
   logic reset;
   int   idle_pct;
   int   beats_sent;
   int   fail_count;
   int   pending_count;
   int   wide_lim;
   int   high_lim;

   gpcc_req_if req_bus ();
   gpcc_rsp_if rsp_bus ();
   gpcc_csr_if csr_bus ();

   grid_path_connection_check_core DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus),
      .csr_if (csr_bus)
   );

   gpcc_conn_checker conn_check (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_bus),
      .rsp_mon       (rsp_bus),
      .csr_mon       (csr_bus),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #40_000_000;
      $display("tb_grid_path_connection_check_core: done, errors");
      $finish;
   end

   initial begin : rsp_drain
      int hold;
      hold = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold > 0) begin
            rsp_bus.ready <= 1'b0;
            hold--;
         end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            rsp_bus.ready <= 1'b0;
            hold = $urandom_range(0, 2);
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   task automatic send_item(input func_type f, input int fx, input int fy,
                            input int tx, input int ty, input bit walk);
      int gap;
      if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
         req_bus.valid <= 1'b0;
         gap = $urandom_range(1, 3);
         repeat (gap) @(negedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.func          <= f;
      req_bus.from_x        <= COORD_W'(fx);
      req_bus.from_y        <= COORD_W'(fy);
      req_bus.to_x          <= COORD_W'(tx);
      req_bus.to_y          <= COORD_W'(ty);
      req_bus.cell_walkable <= walk;
      do @(posedge clock); while (!req_bus.ready);
      beats_sent++;
      @(negedge clock);
   endtask

   task automatic write_cell(input int x, input int y, input bit walk);
      send_item(FUNC_WRITE, x, y, int'($urandom), int'($urandom), walk);
   endtask

   task automatic check_move(input int fx, input int fy, input int tx, input int ty);
      send_item(FUNC_CHECK, fx, fy, tx, ty, 1'($urandom));
   endtask

   task automatic write_reg(input csr_idx_type idx, input int value);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.wdata <= SIZE_W'(value);
      do @(posedge clock); while (!csr_bus.ready);
      @(negedge clock);
   endtask

   task automatic drain(input int extra);
      req_bus.valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (extra) @(negedge clock);
   endtask

   task automatic set_size(input int w, input int h);
      write_reg(CSR_GRID_WIDTH, w);
      write_reg(CSR_GRID_HEIGHT, h);
      csr_bus.valid <= 1'b0;
      wide_lim = (w > GPCC_GRID_SIDE) ? GPCC_GRID_SIDE : w;
      high_lim = (h > GPCC_GRID_SIDE) ? GPCC_GRID_SIDE : h;
   endtask

   function automatic int pick_coord(input int lim);
      logic signed [COORD_W-1:0] raw;
      int r;
      r = $urandom_range(0, 9);
      raw = COORD_W'($urandom);
      if (r < 7) return $urandom_range(0, 19);
      if (r < 9) return lim - 2 + int'($urandom_range(0, 3));
      return raw;
   endfunction

   task automatic paint_block();
      int x0, y0, w, h, i, j, k;
      x0 = $urandom_range(0, 18);
      y0 = $urandom_range(0, 18);
      w = $urandom_range(0, 3);
      h = $urandom_range(0, 3);
      for (j = 0; j <= h; j++)
         for (i = 0; i <= w; i++)
            write_cell(x0 + i, y0 + j, $urandom_range(0, 9) != 0);
      for (k = 0; k < 2; k++)
         check_move(x0 + int'($urandom_range(0, w)), y0 + int'($urandom_range(0, h)),
                    x0 + int'($urandom_range(0, w)), y0 + int'($urandom_range(0, h)));
   endtask

   task automatic random_item();
      int r, s, fx, fy, tx, ty;
      r = $urandom_range(0, 9);
      fx = pick_coord(wide_lim);
      fy = pick_coord(high_lim);
      if (r < 2) begin
         paint_block();
      end else if (r < 8) begin
         s = $urandom_range(0, 9);
         if (s < 3) begin
            tx = fx + int'($urandom_range(0, 2)) - 1;
            ty = fy + int'($urandom_range(0, 2)) - 1;
         end else if (s < 8) begin
            tx = fx + int'($urandom_range(0, 16)) - 8;
            ty = fy + int'($urandom_range(0, 16)) - 8;
         end else begin
            tx = pick_coord(wide_lim);
            ty = pick_coord(high_lim);
         end
         check_move(fx, fy, tx, ty);
      end else if (r < 9) begin
         write_cell(fx, fy, $urandom_range(0, 3) != 0);
      end else begin
         send_item(func_type'($urandom_range(0, 1)), int'($urandom), int'($urandom),
                   int'($urandom), int'($urandom), 1'($urandom));
      end
   endtask

   initial begin : stimulus
      int w_tab[PHASES] = '{20, 511, 1, 0, 17, 256, 30, 300};
      int h_tab[PHASES] = '{20, 300, 256, 5, 9, 256, 400, 2};
      int idle_tab[PHASES] = '{30, 0, 40, 25, 50, 0, 30, 0};
      int p, target;
      reset = 1'b1;
      idle_pct = 0;
      beats_sent = 0;
      wide_lim = GPCC_GRID_SIDE;
      high_lim = GPCC_GRID_SIDE;
      req_bus.valid = 1'b0;
      req_bus.func = FUNC_WRITE;
      req_bus.from_x = '0;
      req_bus.from_y = '0;
      req_bus.to_x = '0;
      req_bus.to_y = '0;
      req_bus.cell_walkable = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.index = CSR_GRID_WIDTH;
      csr_bus.wdata = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      idle_pct = 20;
      write_cell(0, 0, 1'b1);
      write_cell(1, 0, 1'b1);
      write_cell(0, 1, 1'b1);
      write_cell(1, 1, 1'b1);
      write_cell(2, 2, 1'b1);
      send_item(FUNC_WRITE, 3, 3, 511, -512, 1'b1);
      write_cell(255, 255, 1'b1);
      write_cell(-1, 4, 1'b1);
      write_cell(256, 0, 1'b1);
      write_cell(511, 511, 1'b1);
      write_cell(-512, -512, 1'b0);
      check_move(5, 5, 5, 5);
      check_move(-512, -512, -511, -512);
      check_move(511, 511, 511, 510);
      check_move(0, 0, 1, 1);
      check_move(1, 1, 2, 2);
      check_move(255, 255, 256, 254);
      check_move(0, 0, 3, 3);
      check_move(0, 0, 2, 0);
      check_move(0, 0, 511, 511);
      check_move(-512, -512, 511, 511);
      check_move(511, -512, -512, 511);
      check_move(0, 1, 0, -1);
      drain(16);

      set_size(0, 0);
      check_move(0, 0, 0, 0);
      check_move(0, 0, 1, 1);
      check_move(0, 0, 2, 2);
      drain(16);

      for (p = 0; p < PHASES; p++) begin
         if (p == 6) set_size($urandom_range(2, 40), $urandom_range(257, 511));
         else set_size(w_tab[p], h_tab[p]);
         idle_pct = idle_tab[p];
         target = beats_sent + PHASE_BEATS;
         while (beats_sent < target) random_item();
         drain(16);
      end

      drain(300);
      if (fail_count == 0) $display("tb_grid_path_connection_check_core: done, clean");
      else $display("tb_grid_path_connection_check_core: done, errors");
      $finish;
   end

endmodule

>>> files.f
rtl/core/gpcc_pkg.sv
rtl/core/gpcc_ifs.sv
rtl/core/gpcc_grid_map.sv
rtl/core/grid_path_connection_check_core.sv
tb/gpcc_conn_checker.sv
tb/tb_grid_path_connection_check_core.sv
